// ===== hw/rtl/utf8vd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants of the validating UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8vd_pkg;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2  = 21'h000080;
  localparam logic [20:0] MIN_CP3  = 21'h000800;
  localparam logic [20:0] MIN_CP4  = 21'h010000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_bytes;
    logic        malformed;
    logic        run_last;
    logic        text_last;
  } out_item_t;

  // At most one request per byte: count results, all replacements but the last
  typedef struct packed {
    logic [2:0]  count;
    logic [20:0] last_cp;
    logic [2:0]  last_len;
    logic        last_bad;
    logic        eot;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== hw/rtl/utf8vd_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and classifies each byte, pushing a
// request for the result stage when the byte yields results.
// ----------------------------------------------------------------------------
module utf8vd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  utf8vd_pkg::in_item_t byte_data,
  input  utf8vd_pkg::q_status_t q_status,
  output logic                 push,
  output utf8vd_pkg::cmd_t     push_cmd
);
  import utf8vd_pkg::*;

  logic [20:0] accum_value, accum_value_next;
  logic [2:0]  seq_length, seq_length_next;
  logic [1:0]  bytes_held, bytes_held_next;

  logic [7:0]  b;
  logic        eot, seq_open, cont, complete, bad_val, overlong, accept;
  logic [20:0] acc, lead_bits;
  logic [2:0]  held_inc, pre, lead_len;
  cmd_t        cmd;

  assign b        = byte_data.in_byte;
  assign eot      = byte_data.end_of_text;
  assign seq_open = (seq_length != 3'd0);
  assign cont     = (b[7:6] == 2'b10);
  assign acc      = {accum_value[14:0], b[5:0]};
  assign held_inc = {1'b0, bytes_held} + 3'd1;
  assign complete = (held_inc >= seq_length);
  assign overlong = ((seq_length == 3'd2) && (acc < MIN_CP2)) ||
                    ((seq_length == 3'd3) && (acc < MIN_CP3)) ||
                    ((seq_length == 3'd4) && (acc < MIN_CP4));
  assign bad_val  = overlong || (acc > MAX_CP) || ((acc >= SURR_LO) && (acc <= SURR_HI));
  assign pre      = seq_open ? {1'b0, bytes_held} : 3'd0;

  always_comb begin
    lead_len  = 3'd0;
    lead_bits = 21'd0;
    if (b[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.last_cp      = REPL_CP;
    cmd.last_len     = 3'd1;
    cmd.last_bad     = 1'b1;
    cmd.eot          = eot;
    accum_value_next = 21'd0;
    seq_length_next  = 3'd0;
    bytes_held_next  = 2'd0;
    if (seq_open && cont) begin
      if (complete) begin
        if (bad_val) begin
          cmd.count = held_inc;
        end else begin
          cmd.count    = 3'd1;
          cmd.last_cp  = acc;
          cmd.last_len = seq_length;
          cmd.last_bad = 1'b0;
        end
      end else if (eot) begin
        cmd.count = held_inc;
      end else begin
        accum_value_next = acc;
        seq_length_next  = seq_length;
        bytes_held_next  = held_inc[1:0];
      end
    end else begin
      if (!b[7]) begin
        cmd.count    = pre + 3'd1;
        cmd.last_cp  = {13'd0, b};
        cmd.last_len = 3'd1;
        cmd.last_bad = 1'b0;
      end else if ((lead_len != 3'd0) && !eot) begin
        cmd.count        = pre;
        accum_value_next = lead_bits;
        seq_length_next  = lead_len;
        bytes_held_next  = 2'd1;
      end else begin
        cmd.count = pre + 3'd1;
      end
    end
  end

  assign byte_ready = !q_status.full;
  assign accept     = byte_valid && byte_ready;
  assign push       = accept && (cmd.count != 3'd0);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_value <= 21'd0;
      seq_length  <= 3'd0;
      bytes_held  <= 2'd0;
    end else if (accept) begin
      accum_value <= accum_value_next;
      seq_length  <= seq_length_next;
      bytes_held  <= bytes_held_next;
    end
  end

endmodule

// ===== hw/rtl/utf8vd_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder request queue
// Four-entry queue of requests between the front end and the result stage.
// ----------------------------------------------------------------------------
module utf8vd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  utf8vd_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output utf8vd_pkg::cmd_t      head_cmd,
  output utf8vd_pkg::q_status_t q_status
);
  import utf8vd_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_cmd       = entries[rd_ptr];
  assign q_status.valid = (count != '0);
  assign q_status.full  = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/utf8vd_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder result stage
// Expands each request into its results and holds them in an output register.
// ----------------------------------------------------------------------------
module utf8vd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  utf8vd_pkg::cmd_t       head_cmd,
  input  utf8vd_pkg::q_status_t  q_status,
  output logic                   pop,
  output logic                   cp_valid,
  input  logic                   cp_ready,
  output utf8vd_pkg::out_item_t  cp_data
);
  import utf8vd_pkg::*;

  logic [1:0] sent;
  logic       load, is_last;
  out_item_t  item;

  assign load    = q_status.valid && (!cp_valid || cp_ready);
  assign is_last = ({1'b0, sent} == (head_cmd.count - 3'd1));
  assign pop     = load && is_last;

  always_comb begin
    if (is_last) begin
      item.code_point = head_cmd.last_cp;
      item.seq_bytes  = head_cmd.last_len;
      item.malformed  = head_cmd.last_bad;
      item.run_last   = 1'b1;
      item.text_last  = head_cmd.eot;
    end else begin
      item.code_point = REPL_CP;
      item.seq_bytes  = 3'd1;
      item.malformed  = 1'b1;
      item.run_last   = 1'b0;
      item.text_last  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
      sent     <= 2'd0;
    end else begin
      if (load) begin
        cp_valid <= 1'b1;
        sent     <= is_last ? 2'd0 : sent + 2'd1;
      end else if (cp_ready) begin
        cp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_validating_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Path: a byte's first result passes the request queue, then the output register.
// Throughput: one byte per cycle while the request queue is not full; a byte giving
// k results sends them out in turn, with a four-request queue absorbing the burst.
// Reset: clears the open sequence, the request queue and the output valid.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  utf8vd_pkg::in_item_t  byte_data,
  output logic                  cp_valid,
  input  logic                  cp_ready,
  output utf8vd_pkg::out_item_t cp_data
);
  import utf8vd_pkg::*;

  logic      push, pop;
  cmd_t      push_cmd, head_cmd;
  q_status_t q_status;

  utf8vd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  utf8vd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  utf8vd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_cmd (head_cmd),
    .q_status (q_status),
    .pop      (pop),
    .cp_valid (cp_valid),
    .cp_ready (cp_ready),
    .cp_data  (cp_data)
  );

endmodule
